@@ rtl/core/fbpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// shared types and constants of the fixed block pool allocator
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int POOL_DEPTH_DEF = 1024;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int CNT_W   = 11;
    localparam int BIDX_W  = 10;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;
    localparam int CFGA_W  = 2;
    localparam int PROD_W  = CNT_W + SIZE_W;
    localparam int STEP_W  = 4;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(8);

    localparam logic [ADDR_W-1:0] CFG_BASE_RST  = '0;
    localparam logic [SIZE_W-1:0] CFG_SIZE_RST  = SIZE_W'(8);
    localparam logic [CNT_W-1:0]  CFG_COUNT_RST = CNT_W'(1024);

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 3'd0,
        FN_FREE  = 3'd1,
        FN_INDEX = 3'd2,
        FN_ADDR  = 3'd3,
        FN_RESET = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EXHAUST  = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_BAD_ADDR = 2'd3
    } t_status;

    typedef enum logic [CFGA_W-1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_BLOCK_SIZE  = 2'd1,
        CFG_BLOCK_COUNT = 2'd2
    } t_cfg_reg;

endpackage

@@ rtl/core/fixed_block_pool_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// free list allocator over a pool of equal blocks, links held in one memory
// ----------------------------------------------------------------------------
// channel   dir  tdata / tuser (low bit up)
// s_axis    in   tdata: address[31:0] request_bytes[47:32] block_index[57:48]
//                tuser: func[2:0]
// m_axis    out  tdata: result_address[31:0] result_index[41:32] status[43:42]
// cfg       in   i_cfg_we, i_cfg_addr (register index), i_cfg_wdata
//
// allocate, address-of-index, unknown codes and rejected requests pass from
// transfer through S_MUL, S_EVAL and S_DONE to the output register; free and
// index-of that pass the size and bound checks add a bit-serial division by
// the block size in S_DIV. pool reset writes the link memory one entry a cycle:
// block_count entries (at least one, capped at POOL_DEPTH). after i_rst_n the
// same pass runs over min(1024, POOL_DEPTH) entries with s_axis_tready low. one
// item is in work at a time; a finished result waits in the output register
// while the next item is taken.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [fbpa_pkg::S_TDATA_W-1:0] s_axis_tdata,   // address, request_bytes, block_index
    input  logic [fbpa_pkg::FUNC_W-1:0]    s_axis_tuser,   // func
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [fbpa_pkg::M_TDATA_W-1:0] m_axis_tdata,   // result_address, result_index, status
    input  logic                           i_cfg_we,
    input  logic [fbpa_pkg::CFGA_W-1:0]    i_cfg_addr,
    input  logic [fbpa_pkg::ADDR_W-1:0]    i_cfg_wdata
);
    import fbpa_pkg::*;

    localparam int IDX_W    = $clog2(POOL_DEPTH);
    localparam int RST_CNT  = (int'(CFG_COUNT_RST) > POOL_DEPTH) ? POOL_DEPTH
                                                                 : int'(CFG_COUNT_RST);
    localparam logic [IDX_W-1:0] RST_LAST = IDX_W'(RST_CNT - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,
        S_MUL   = 6'b000100,
        S_EVAL  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;

    logic [ADDR_W-1:0] r_pool_base;
    logic [SIZE_W-1:0] r_block_size;
    logic [CNT_W-1:0]  r_block_count;

    logic [IDX_W-1:0]  r_head;
    logic              r_head_valid;
    logic [IDX_W-1:0]  r_sweep_i;
    logic [IDX_W-1:0]  r_sweep_last;
    logic              r_sweep_reply;

    t_func             r_func;
    logic [SIZE_W-1:0] r_req;
    logic [BIDX_W-1:0] r_bidx;
    logic [ADDR_W-1:0] r_off;
    logic [PROD_W-1:0] r_prod;
    logic [ADDR_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_quot;
    logic [STEP_W-1:0] r_step;

    logic [ADDR_W-1:0] r_res_addr;
    logic [BIDX_W-1:0] r_res_idx;
    t_status           r_res_status;

    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [BIDX_W-1:0] r_out_idx;
    t_status           r_out_status;

    logic [IDX_W:0]    r_mem [POOL_DEPTH];
    logic [IDX_W:0]    r_rdata;

    logic [SIZE_W-1:0] eff_size;
    logic [CNT_W-1:0]  eff_count;
    logic [CNT_W-1:0]  mul_a;
    logic [ADDR_W-1:0] head_w;
    logic [ADDR_W-1:0] trial;
    logic [ADDR_W-1:0] n_rem;
    logic [CNT_W-1:0]  n_quot;
    logic [ADDR_W-1:0] quot_w;
    logic [IDX_W-1:0]  quot_idx;
    logic [IDX_W-1:0]  n_sweep_i;
    logic [ADDR_W-1:0] prod_w;
    logic [ADDR_W-1:0] calc_addr;
    logic              in_bounds;
    logic              div_last;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W:0]    mem_wdata;
    logic              s_xfer;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - ADDR_W - BIDX_W - STAT_W){1'b0}},
                            r_out_status, r_out_idx, r_out_addr};

    always_comb begin
        eff_size = (r_block_size < MIN_SIZE) ? MIN_SIZE : r_block_size;
        if (r_block_count == '0) begin
            eff_count = CNT_W'(1);
        end else if (32'(r_block_count) > 32'(POOL_DEPTH)) begin
            eff_count = CNT_W'(POOL_DEPTH);
        end else begin
            eff_count = r_block_count;
        end
    end

    always_comb begin
        head_w = 32'(r_head);
        case (r_func)
            FN_ALLOC: mul_a = head_w[CNT_W-1:0];
            FN_FREE:  mul_a = eff_count;
            FN_INDEX: mul_a = eff_count;
            FN_ADDR:  mul_a = {1'b0, r_bidx};
            default:  mul_a = '0;
        endcase
    end

    assign prod_w    = {{(ADDR_W - PROD_W){1'b0}}, r_prod};
    assign calc_addr = r_pool_base + prod_w;
    assign in_bounds = (r_off < prod_w);

    // one quotient bit a cycle, most significant first
    always_comb begin
        trial = {{(ADDR_W - SIZE_W){1'b0}}, eff_size} << r_step;
        if (r_rem >= trial) begin
            n_rem  = r_rem - trial;
            n_quot = {r_quot[CNT_W-2:0], 1'b1};
        end else begin
            n_rem  = r_rem;
            n_quot = {r_quot[CNT_W-2:0], 1'b0};
        end
        quot_w   = 32'(n_quot);
        quot_idx = quot_w[IDX_W-1:0];
        div_last = (r_state == S_DIV) && (r_step == '0);
    end

    assign n_sweep_i = r_sweep_i + 1'b1;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep_i;
        mem_wdata = {r_sweep_i != r_sweep_last, n_sweep_i};
        if (r_state == S_SWEEP) begin
            mem_we = 1'b1;
        end else if (div_last && (n_rem == '0) && (r_func == FN_FREE)) begin
            mem_we    = 1'b1;
            mem_waddr = quot_idx;
            mem_wdata = {r_head_valid, r_head};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_IDLE) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_pool_base   <= CFG_BASE_RST;
            r_block_size  <= CFG_SIZE_RST;
            r_block_count <= CFG_COUNT_RST;
            r_head        <= '0;
            r_head_valid  <= 1'b1;
            r_sweep_i     <= '0;
            r_sweep_last  <= RST_LAST;
            r_sweep_reply <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_POOL_BASE:   r_pool_base   <= i_cfg_wdata;
                    CFG_BLOCK_SIZE:  r_block_size  <= i_cfg_wdata[SIZE_W-1:0];
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == S_DONE) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        r_func       <= t_func'(s_axis_tuser);
                        r_off        <= s_axis_tdata[ADDR_W-1:0] - r_pool_base;
                        r_req        <= s_axis_tdata[ADDR_W +: SIZE_W];
                        r_bidx       <= s_axis_tdata[ADDR_W + SIZE_W +: BIDX_W];
                        r_res_addr   <= '0;
                        r_res_idx    <= '0;
                        r_res_status <= ST_OK;
                        r_state      <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= {{SIZE_W{1'b0}}, mul_a} * {{CNT_W{1'b0}}, eff_size};
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_rem   <= r_off;
                    r_quot  <= '0;
                    r_step  <= STEP_W'(CNT_W - 1);
                    case (r_func)
                        FN_ALLOC: begin
                            r_state <= S_DONE;
                            if (r_req > eff_size) begin
                                r_res_status <= ST_BAD_SIZE;
                            end else if (!r_head_valid) begin
                                r_res_status <= ST_EXHAUST;
                            end else begin
                                r_res_addr   <= calc_addr;
                                r_head_valid <= r_rdata[IDX_W];
                                r_head       <= r_rdata[IDX_W-1:0];
                            end
                        end
                        FN_FREE: begin
                            if (r_req != eff_size) begin
                                r_res_status <= ST_BAD_SIZE;
                                r_state      <= S_DONE;
                            end else if (!in_bounds) begin
                                r_res_status <= ST_BAD_ADDR;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        FN_INDEX: begin
                            if (!in_bounds) begin
                                r_res_status <= ST_BAD_ADDR;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        FN_ADDR: begin
                            r_state <= S_DONE;
                            if ({1'b0, r_bidx} >= eff_count) begin
                                r_res_status <= ST_BAD_ADDR;
                            end else begin
                                r_res_addr <= calc_addr;
                            end
                        end
                        FN_RESET: begin
                            r_head        <= '0;
                            r_head_valid  <= 1'b1;
                            r_sweep_i     <= '0;
                            r_sweep_last  <= IDX_W'(eff_count - 1'b1);
                            r_sweep_reply <= 1'b1;
                            r_state       <= S_SWEEP;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quot <= n_quot;
                    r_step <= r_step - 1'b1;
                    if (div_last) begin
                        r_state <= S_DONE;
                        if (n_rem != '0) begin
                            r_res_status <= ST_BAD_ADDR;
                        end else if (r_func == FN_FREE) begin
                            r_head       <= quot_idx;
                            r_head_valid <= 1'b1;
                        end else begin
                            r_res_idx <= n_quot[BIDX_W-1:0];
                        end
                    end
                end
                S_SWEEP: begin
                    r_sweep_i <= n_sweep_i;
                    if (r_sweep_i == r_sweep_last) begin
                        r_state <= r_sweep_reply ? S_DONE : S_IDLE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_addr   <= r_res_addr;
                        r_out_idx    <= r_res_idx;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sim/tb_fixed_block_pool_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator_unit
// self-checking bench for the free list pool allocator: requests go in over
// s_axis, every result on m_axis is compared field by field with a local
// model of the free list, the link table and the pool registers; a directed
// pass hits the field extremes and every error path, random phases sweep the
// pool registers and mix well-formed alloc/free traffic with noise, and both
// sides stall in random bursts, with one long output hold-off
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_unit;

    import fbpa_pkg::*;

    localparam int          CLK_HALF       = 10;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DEPTH          = POOL_DEPTH_DEF;
    localparam int          FUNC_MAX       = (1 << FUNC_W) - 1;
    localparam int          RAND_PHASES    = 16;
    localparam int          PHASE_ITEMS    = 60;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BIDX_W-1:0] idx;
        t_status           status;
    } pool_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [FUNC_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFGA_W-1:0]     i_cfg_addr;
    logic [ADDR_W-1:0]     i_cfg_wdata;

    // model of the pool
    logic [ADDR_W-1:0]     pool_base_q;
    logic [SIZE_W-1:0]     block_size_q;
    logic [CNT_W-1:0]      block_count_q;
    logic [BIDX_W-1:0]     head_blk;
    logic                  head_ok;
    logic [BIDX_W-1:0]     link_next [DEPTH];
    logic                  link_ok   [DEPTH];

    pool_result_t          pending_results [$];
    logic [ADDR_W-1:0]     live_blocks [$];

    int                    mismatch_cnt;
    int                    idle_cycles;
    int                    src_gap_pct;
    int                    sink_stall_pct;
    int                    sink_hold;
    int                    sink_burst;
    int                    op_count [FUNC_MAX+1];
    int                    status_count [4];
    int                    config_phases;

    always #CLK_HALF i_clk = ~i_clk;

    fixed_block_pool_allocator_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // pool model
    // ------------------------------------------------------------------------
    function automatic logic [SIZE_W-1:0] block_bytes();
        return (block_size_q < MIN_SIZE) ? MIN_SIZE : block_size_q;
    endfunction

    function automatic logic [CNT_W-1:0] block_total();
        if (block_count_q == '0) begin
            return CNT_W'(1);
        end
        if (block_count_q > CNT_W'(DEPTH)) begin
            return CNT_W'(DEPTH);
        end
        return block_count_q;
    endfunction

    function automatic logic [ADDR_W-1:0] block_addr(input logic [CNT_W-1:0] blk);
        return pool_base_q + ADDR_W'(blk) * ADDR_W'(block_bytes());
    endfunction

    function automatic logic find_block(input logic [ADDR_W-1:0] addr,
                                        output logic [BIDX_W-1:0] blk);
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] bytes;
        logic [ADDR_W+CNT_W-1:0] span;
        bytes = ADDR_W'(block_bytes());
        off   = addr - pool_base_q;
        span  = (ADDR_W+CNT_W)'(block_total()) * (ADDR_W+CNT_W)'(bytes);
        blk   = BIDX_W'(off / bytes);
        return ((ADDR_W+CNT_W)'(off) < span) && (off % bytes == '0);
    endfunction

    task automatic rebuild_free_list();
        int n;
        n = int'(block_total());
        for (int i = 0; i < DEPTH; i++) begin
            link_next[i] = '0;
            link_ok[i]   = 1'b0;
        end
        for (int i = 0; i + 1 < n; i++) begin
            link_next[i] = BIDX_W'(i + 1);
            link_ok[i]   = 1'b1;
        end
        head_blk = '0;
        head_ok  = 1'b1;
    endtask

    task automatic predict_pool_result(input logic [FUNC_W-1:0] fn,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [SIZE_W-1:0] req,
                                       input logic [BIDX_W-1:0] bidx,
                                       output pool_result_t res);
        logic [BIDX_W-1:0] blk;
        res.addr   = '0;
        res.idx    = '0;
        res.status = ST_OK;
        case (fn)
            FN_ALLOC: begin
                if (req > block_bytes()) begin
                    res.status = ST_BAD_SIZE;
                end else if (!head_ok) begin
                    res.status = ST_EXHAUST;
                end else begin
                    blk      = head_blk;
                    res.addr = block_addr(CNT_W'(blk));
                    head_ok  = link_ok[blk];
                    head_blk = link_next[blk];
                end
            end
            FN_FREE: begin
                if (req != block_bytes()) begin
                    res.status = ST_BAD_SIZE;
                end else if (!find_block(addr, blk)) begin
                    res.status = ST_BAD_ADDR;
                end else begin
                    link_next[blk] = head_blk;
                    link_ok[blk]   = head_ok;
                    head_blk       = blk;
                    head_ok        = 1'b1;
                end
            end
            FN_INDEX: begin
                if (!find_block(addr, blk)) begin
                    res.status = ST_BAD_ADDR;
                end else begin
                    res.idx = blk;
                end
            end
            FN_ADDR: begin
                if (CNT_W'(bidx) >= block_total()) begin
                    res.status = ST_BAD_ADDR;
                end else begin
                    res.addr = block_addr(CNT_W'(bidx));
                end
            end
            FN_RESET: begin
                rebuild_free_list();
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------------
    task automatic src_pause(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [FUNC_W-1:0] fn,
                                input logic [ADDR_W-1:0] addr,
                                input logic [SIZE_W-1:0] req,
                                input logic [BIDX_W-1:0] bidx);
        pool_result_t res;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({bidx, req, addr});
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_pool_result(fn, addr, req, bidx, res);
        pending_results.push_back(res);
        op_count[fn]++;
        if (fn == FN_ALLOC && res.status == ST_OK) begin
            live_blocks.push_back(res.addr);
        end else if (fn == FN_RESET) begin
            live_blocks.delete();
        end
        if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
            src_pause($urandom_range(1, 16));
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_reg r, input logic [ADDR_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= r;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (r)
            CFG_POOL_BASE:   pool_base_q   = val;
            CFG_BLOCK_SIZE:  block_size_q  = val[SIZE_W-1:0];
            CFG_BLOCK_COUNT: block_count_q = val[CNT_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_config(input logic [ADDR_W-1:0] base,
                                input logic [SIZE_W-1:0] size,
                                input logic [CNT_W-1:0] count);
        wait_drained();
        cfg_write(CFG_POOL_BASE, base);
        cfg_write(CFG_BLOCK_SIZE, ADDR_W'(size));
        cfg_write(CFG_BLOCK_COUNT, ADDR_W'(count));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        live_blocks.delete();
        config_phases++;
    endtask

    // mostly well-formed alloc/free traffic with random content, some noise
    task automatic send_random_request();
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] req;
        logic [BIDX_W-1:0] bidx;
        logic [CNT_W-1:0]  blk;
        int                pick;
        int                k;
        pick = $urandom_range(0, 99);
        fn   = FN_ALLOC;
        addr = $urandom;
        req  = SIZE_W'($urandom);
        bidx = BIDX_W'($urandom);
        blk  = CNT_W'($urandom_range(0, int'(block_total()) - 1));
        if (pick < 35) begin
            req = SIZE_W'($urandom_range(0, int'(block_bytes())));
        end else if (pick < 60) begin
            fn  = FN_FREE;
            req = block_bytes();
            if (live_blocks.size() != 0) begin
                k    = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[k];
                live_blocks.delete(k);
            end else begin
                addr = block_addr(blk);
            end
        end else if (pick < 70) begin
            fn   = FN_INDEX;
            addr = block_addr(blk);
        end else if (pick < 80) begin
            fn = FN_ADDR;
            if ($urandom_range(0, 3) != 0) begin
                bidx = BIDX_W'(blk);
            end
        end else if (pick < 83) begin
            fn = FN_RESET;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    fn = FUNC_W'($urandom_range(0, FUNC_MAX));
                end
                1: begin
                    fn   = ($urandom_range(0, 1) != 0) ? FN_FREE : FN_INDEX;
                    req  = block_bytes();
                    addr = block_addr(blk) + ADDR_W'($urandom_range(1, int'(block_bytes()) - 1));
                end
                2: begin
                    fn   = ($urandom_range(0, 1) != 0) ? FN_FREE : FN_INDEX;
                    req  = block_bytes();
                    addr = ($urandom_range(0, 1) != 0) ? block_addr(block_total())
                                                       : pool_base_q - ADDR_W'(block_bytes());
                end
                default: begin
                    fn = ($urandom_range(0, 1) != 0) ? FN_FREE : FN_ALLOC;
                    if (block_bytes() != '1) begin
                        req = block_bytes() + SIZE_W'($urandom_range(1, 4));
                    end
                    addr = block_addr(blk);
                end
            endcase
        end
        send_request(fn, addr, req, bidx);
    endtask

    // ------------------------------------------------------------------------
    // sink side, result check, watchdog
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold--;
        end else if (sink_burst > 0) begin
            m_axis_tready <= 1'b0;
            sink_burst--;
        end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
            m_axis_tready <= 1'b0;
            sink_burst = $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        pool_result_t      want;
        logic [ADDR_W-1:0] got_addr;
        logic [BIDX_W-1:0] got_idx;
        logic [STAT_W-1:0] got_status;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_addr   = m_axis_tdata[31:0];
            got_idx    = m_axis_tdata[41:32];
            got_status = m_axis_tdata[43:42];
            status_count[got_status]++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, tdata 0x%0h",
                                          m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got_addr !== want.addr) begin
                    report_mismatch($sformatf("result_address 0x%08h, want 0x%08h",
                                              got_addr, want.addr));
                end
                if (got_idx !== want.idx) begin
                    report_mismatch($sformatf("result_index %0d, want %0d",
                                              got_idx, want.idx));
                end
                if (got_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, want %0d (%s)",
                                              got_status, want.status, want.status.name()));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed_ops();
        wait_drained();
        send_request(FN_ALLOC, '0, '0, '0);
        send_request(FN_ALLOC, '0, SIZE_W'(8), '0);
        send_request(FN_ALLOC, '0, SIZE_W'(9), '0);
        send_request(FN_ALLOC, '0, '1, '0);
        send_request(FN_FREE, '0, SIZE_W'(8), '0);
        send_request(FN_FREE, '0, SIZE_W'(8), '0);     // double free
        send_request(FN_FREE, ADDR_W'(8), '1, '0);
        send_request(FN_FREE, ADDR_W'(4), SIZE_W'(8), '0);
        send_request(FN_FREE, '1, SIZE_W'(8), '0);
        send_request(FN_INDEX, ADDR_W'(8184), '0, '0);
        send_request(FN_INDEX, ADDR_W'(8192), '0, '0);
        send_request(FN_ADDR, '0, '0, '1);
        send_request(FN_ADDR, '0, '0, '0);
        for (int f = int'(FN_RESET) + 1; f <= FUNC_MAX; f++) begin
            send_request(FUNC_W'(f), '1, '1, '1);
        end
        send_request(FN_RESET, '0, '0, '0);
        send_request(FN_ALLOC, '0, '0, '0);
    endtask

    task automatic test_config_extremes();
        // size below a link and zero count, pool wrapping past the top
        apply_config(32'hFFFF_FFF8, SIZE_W'(3), '0);
        send_request(FN_RESET, '0, '0, '0);
        send_request(FN_ALLOC, '0, SIZE_W'(8), '0);
        send_request(FN_ALLOC, '0, '0, '0);
        send_request(FN_ADDR, '0, '0, BIDX_W'(1));
        send_request(FN_INDEX, 32'hFFFF_FFF8, '0, '0);
        send_request(FN_FREE, 32'hFFFF_FFF8, SIZE_W'(8), '0);
        send_request(FN_INDEX, '0, '0, '0);
        // largest block, count above the pool depth
        apply_config('1, '1, '1);
        send_request(FN_RESET, '0, '0, '0);
        send_request(FN_ADDR, '0, '0, '1);
        send_request(FN_INDEX, block_addr(CNT_W'(DEPTH - 1)), '0, '0);
    endtask

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  count;
        int                levels [4];
        levels = '{0, 5, 20, 40};
        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = '1;
                2:       base = $urandom;
                default: base = $urandom & 32'hFFFF_0000;
            endcase
            case ($urandom_range(0, 4))
                0:       size = SIZE_W'($urandom_range(0, 7));
                1:       size = MIN_SIZE;
                2:       size = '1;
                3:       size = SIZE_W'($urandom_range(8, 64));
                default: size = SIZE_W'($urandom_range(8, 65535));
            endcase
            case ($urandom_range(0, 5))
                0:       count = '0;
                1:       count = CNT_W'(1);
                2:       count = CNT_W'($urandom_range(2, 16));
                3:       count = CNT_W'(DEPTH);
                4:       count = CNT_W'($urandom_range(DEPTH + 1, 2047));
                default: count = CNT_W'($urandom_range(1, DEPTH));
            endcase
            apply_config(base, size, count);
            src_gap_pct    = levels[$urandom_range(0, 3)];
            sink_stall_pct = levels[$urandom_range(0, 3)];
            // sometimes keep the old links so a shrunken count still sees them
            if ($urandom_range(0, 9) < 7) begin
                send_request(FN_RESET, '0, '0, '0);
            end
            repeat (PHASE_ITEMS) send_random_request();
        end
    endtask

    task automatic test_backpressure();
        apply_config($urandom, MIN_SIZE, CNT_W'(DEPTH));
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        send_request(FN_RESET, '0, '0, '0);
        sink_hold = 400;
        repeat (40) send_random_request();
        // sender waits for every pending result before going on
        wait_drained();
        src_gap_pct    = 20;
        sink_stall_pct = 20;
    endtask

    task automatic test_streaming_tail();
        apply_config($urandom, SIZE_W'($urandom_range(8, 256)),
                     CNT_W'($urandom_range(4, 64)));
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        send_request(FN_RESET, '0, '0, '0);
        repeat (100) send_random_request();
        wait_drained();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= '0;
        m_axis_tready  <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_addr     <= '0;
        i_cfg_wdata    <= '0;
        mismatch_cnt   = 0;
        idle_cycles    = 0;
        sink_hold      = 0;
        sink_burst     = 0;
        config_phases  = 0;
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        pool_base_q    = CFG_BASE_RST;
        block_size_q   = CFG_SIZE_RST;
        block_count_q  = CFG_COUNT_RST;
        rebuild_free_list();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_ops();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();
        test_streaming_tail();

        repeat (20) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        $display("covered %0d alloc, %0d free, %0d index-of, %0d addr-of, %0d pool reset, %0d unknown",
                 op_count[FN_ALLOC], op_count[FN_FREE], op_count[FN_INDEX],
                 op_count[FN_ADDR], op_count[FN_RESET],
                 op_count[5] + op_count[6] + op_count[7]);
        $display("results: %0d ok, %0d exhausted, %0d bad size, %0d bad address over %0d configs",
                 status_count[ST_OK], status_count[ST_EXHAUST], status_count[ST_BAD_SIZE],
                 status_count[ST_BAD_ADDR], config_phases);
        if (mismatch_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
